/* hdl/shm_pkg.sv */
// Shared types and constants of the stack headroom monitor.
// Used by the divider and the top level.
package shm_pkg;

	// Default thread count; sets the depth of the warned-flag memory
	localparam int MAX_THREADS_DEF = 32;

	// Field widths
	localparam int IDX_W   = 5;
	localparam int BYTES_W = 32;
	localparam int PCT_W   = 7;
	localparam int CNT_W   = 6;
	localparam int QUOT_W  = 7;
	localparam int NUM_W   = BYTES_W + QUOT_W;

	localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0] THRESHOLD_RST = 7'd20;
	localparam logic [CNT_W-1:0] BELOW_MAX     = 6'd63;

	typedef enum logic [1:0] {
		KIND_WARN    = 2'd0,
		KIND_RECOVER = 2'd1,
		KIND_SUMMARY = 2'd2
	} result_kind_t;

	// One result item as it leaves the block
	typedef struct packed {
		result_kind_t         kind;
		logic [IDX_W-1:0]     event_thread;
		logic [BYTES_W-1:0]   event_free_bytes;
		logic [BYTES_W-1:0]   event_size_bytes;
		logic [IDX_W-1:0]     worst_thread;
		logic [BYTES_W-1:0]   worst_free_bytes;
		logic [PCT_W-1:0]     worst_used_percent;
		logic [CNT_W-1:0]     below_count;
		logic                 last_result;
	} result_t;

	// Request to the percent divider
	typedef struct packed {
		logic               start;
		logic [BYTES_W-1:0] free_bytes;
		logic [BYTES_W-1:0] size_bytes;
	} div_req_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_MUL,
		DIV_STEP
	} div_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_EVAL
	} top_state_t;

endpackage

/* hdl/shm_div.sv */
// Iterative free-percent divider: min(free, size) * 100 / size, 0 for size 0.
// Depends on shm_pkg for widths and the request struct.
module shm_div import shm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	div_state_t         state_q, state_d;
	logic [2:0]         step_q;
	logic               done_q;
	logic [BYTES_W-1:0] clamp_q;
	logic [BYTES_W-1:0] size_q;
	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dsh_q;
	logic [QUOT_W-1:0]  quot_q;
	logic               last_step;

	assign last_step = (state_q == DIV_STEP) && (step_q == 3'(QUOT_W - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (req.start) state_d = DIV_MUL;
			end
			DIV_MUL:  state_d = DIV_STEP;
			DIV_STEP: begin
				if (last_step) state_d = DIV_IDLE;
			end
			default:  state_d = DIV_IDLE;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last_step;
			if (state_q == DIV_MUL) step_q <= '0;
			else if (state_q == DIV_STEP) step_q <= step_q + 3'd1;
		end
	end

	// Clamp, scale by 100, then one restoring step per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (req.start) begin
					clamp_q <= (req.free_bytes > req.size_bytes) ? req.size_bytes
						: req.free_bytes;
					size_q  <= req.size_bytes;
				end
			end
			DIV_MUL: begin
				// 100 = 64 + 32 + 4
				rem_q  <= {1'b0, clamp_q, 6'b0} + {2'b0, clamp_q, 5'b0}
					+ {5'b0, clamp_q, 2'b0};
				// a zero size gets an unreachable divisor so the quotient stays 0
				dsh_q  <= (size_q == '0) ? '1 : {1'b0, size_q, 6'b0};
				quot_q <= '0;
			end
			DIV_STEP: begin
				if (rem_q >= dsh_q) begin
					rem_q  <= rem_q - dsh_q;
					quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/shm_flag_ram.sv */
// Warned-flag memory: one bit per thread slot, registered read.
// Valid bits cleared by reset make unwritten slots read as zero.
module shm_flag_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              wr_data
);

	logic             mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic             rd_data_q;

	// Mark written slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= valid_q[rd_addr] & mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/stack_headroom_monitor.sv */
// Top level of the stack headroom monitor.
// Depends on shm_pkg, shm_div and shm_flag_ram.

// One sample is taken at a time and occupies the block through the accept cycle
// (which also reads the thread's warned flag), the clamp and scale by 100, seven
// restoring-division steps of the percent divider, the handoff of the quotient
// and the evaluation. A sample yields at most a warning or recovery followed,
// on the last sample of a tick, by the summary; both wait in a two-deep output
// register, so the next sample is taken while they drain. Evaluation waits for
// that register to empty.
// The threshold register resets to 20 and should be written only while idle.
module stack_headroom_monitor import shm_pkg::*; #(
	parameter int MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample channel
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [IDX_W-1:0]   thread_index,
	input  logic [BYTES_W-1:0] free_bytes,
	input  logic [BYTES_W-1:0] size_bytes,
	input  logic               last_sample,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         result_kind,
	output logic [IDX_W-1:0]   event_thread,
	output logic [BYTES_W-1:0] event_free_bytes,
	output logic [BYTES_W-1:0] event_size_bytes,
	output logic [IDX_W-1:0]   worst_thread,
	output logic [BYTES_W-1:0] worst_free_bytes,
	output logic [PCT_W-1:0]   worst_used_percent,
	output logic [CNT_W-1:0]   below_count,
	output logic               last_result,
	// threshold register
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [PCT_W-1:0]   cfg_data
);

	localparam int SLOT_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int RED_W  = 13;

	top_state_t         state_q, state_d;
	logic               accept;
	logic               load;
	logic               pop;

	logic [PCT_W-1:0]   thresh_q;

	logic [IDX_W-1:0]   idx_q;
	logic [BYTES_W-1:0] free_q;
	logic [BYTES_W-1:0] size_q;
	logic               last_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [RED_W-1:0]   red;
	logic [SLOT_W-1:0]  slot;

	div_req_t           div_req;
	logic               div_done;
	logic [QUOT_W-1:0]  free_pct;

	logic               was_warned;
	logic               below;
	logic               warn_ev;
	logic               recover_ev;
	logic               any_ev;

	logic               have_worst_q;
	logic [PCT_W-1:0]   worst_pct_q;
	logic [IDX_W-1:0]   worst_idx_q;
	logic [BYTES_W-1:0] worst_free_q;
	logic [CNT_W-1:0]   below_total_q;

	logic               take_worst;
	logic [PCT_W-1:0]   worst_pct_d;
	logic [IDX_W-1:0]   worst_idx_d;
	logic [BYTES_W-1:0] worst_free_d;
	logic [CNT_W-1:0]   below_total_d;

	result_t            ev_res;
	result_t            sum_res;
	result_t            first_res;

	logic               head_v_q;
	logic               sec_v_q;
	result_t            head_q;
	result_t            sec_q;

	assign accept = sample_valid && !sample_stall;

	// Reduce the thread index to its flag slot (index mod MAX_THREADS)
	always_comb begin
		red = {{(RED_W - IDX_W){1'b0}}, thread_index};
		for (int k = 4; k >= 0; k--) begin
			if (red >= RED_W'(MAX_THREADS << k)) red = red - RED_W'(MAX_THREADS << k);
		end
		slot = red[SLOT_W-1:0];
	end

	// Threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// Hold the accepted sample
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= thread_index;
			free_q <= free_bytes;
			size_q <= size_bytes;
			last_q <= last_sample;
			slot_q <= slot;
		end
	end

	assign div_req.start      = accept;
	assign div_req.free_bytes = free_bytes;
	assign div_req.size_bytes = size_bytes;

	shm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (free_pct)
	);

	shm_flag_ram #(
		.DEPTH  (MAX_THREADS),
		.ADDR_W (SLOT_W)
	) u_flags (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (slot),
		.rd_data (was_warned),
		.wr_en   (state_q == ST_EVAL && !head_v_q && any_ev),
		.wr_addr (slot_q),
		.wr_data (warn_ev)
	);

	// Classify the sample
	assign below      = free_pct < thresh_q;
	assign warn_ev    = below && !was_warned;
	assign recover_ev = !below && was_warned;
	assign any_ev     = warn_ev || recover_ev;

	// Tick tracking after this sample
	always_comb begin
		take_worst    = !have_worst_q || (free_pct < worst_pct_q);
		worst_pct_d   = take_worst ? free_pct : worst_pct_q;
		worst_idx_d   = take_worst ? idx_q : worst_idx_q;
		worst_free_d  = take_worst ? free_q : worst_free_q;
		below_total_d = (below && below_total_q != BELOW_MAX) ? below_total_q + 6'd1
			: below_total_q;
	end

	// Build the result items
	always_comb begin
		ev_res                    = '0;
		ev_res.kind               = warn_ev ? KIND_WARN : KIND_RECOVER;
		ev_res.event_thread       = idx_q;
		ev_res.event_free_bytes   = warn_ev ? free_q : '0;
		ev_res.event_size_bytes   = warn_ev ? size_q : '0;
		ev_res.last_result        = !last_q;

		sum_res                    = '0;
		sum_res.kind               = KIND_SUMMARY;
		sum_res.worst_thread       = worst_idx_d;
		sum_res.worst_free_bytes   = worst_free_d;
		sum_res.worst_used_percent = PCT_FULL - worst_pct_d;
		sum_res.below_count        = below_total_d;
		sum_res.last_result        = 1'b1;

		first_res = any_ev ? ev_res : sum_res;
	end

	// Next state
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!head_v_q) begin
					load    = any_ev || last_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Advance tick state on evaluation; clear it after a summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_worst_q  <= 1'b0;
			worst_pct_q   <= '0;
			worst_idx_q   <= '0;
			worst_free_q  <= '0;
			below_total_q <= '0;
		end else if (state_q == ST_EVAL && !head_v_q) begin
			if (last_q) begin
				have_worst_q  <= 1'b0;
				worst_pct_q   <= '0;
				worst_idx_q   <= '0;
				worst_free_q  <= '0;
				below_total_q <= '0;
			end else begin
				have_worst_q  <= 1'b1;
				worst_pct_q   <= worst_pct_d;
				worst_idx_q   <= worst_idx_d;
				worst_free_q  <= worst_free_d;
				below_total_q <= below_total_d;
			end
		end
	end

	// Two-deep output register
	assign pop = head_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			sec_v_q  <= 1'b0;
		end else if (load) begin
			head_v_q <= 1'b1;
			sec_v_q  <= any_ev && last_q;
		end else if (pop) begin
			head_v_q <= sec_v_q;
			sec_v_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= first_res;
			sec_q  <= sum_res;
		end else if (pop && sec_v_q) begin
			head_q <= sec_q;
		end
	end

	// Drive the result transfer
	assign result_valid       = head_v_q;
	assign result_kind        = head_q.kind;
	assign event_thread       = head_q.event_thread;
	assign event_free_bytes   = head_q.event_free_bytes;
	assign event_size_bytes   = head_q.event_size_bytes;
	assign worst_thread       = head_q.worst_thread;
	assign worst_free_bytes   = head_q.worst_free_bytes;
	assign worst_used_percent = head_q.worst_used_percent;
	assign below_count        = head_q.below_count;
	assign last_result        = head_q.last_result;

endmodule

/* bench/tb_stack_headroom_monitor.sv */
`timescale 1ns / 100ps
// Self-checking bench for stack_headroom_monitor: directed and random stack samples,
// threshold writes between phases, results checked against an in-bench predictor.
// Depends on shm_pkg and the stack_headroom_monitor RTL.
module tb_stack_headroom_monitor import shm_pkg::*; ();

	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 24;
	localparam int STUCK_LIMIT   = 4000;

	typedef enum logic [1:0] {
		CMD_SAMPLE,
		CMD_THRESHOLD,
		CMD_DRAIN,
		CMD_PACE
	} stim_op_t;

	typedef struct {
		stim_op_t           op;
		logic [IDX_W-1:0]   idx;
		logic [BYTES_W-1:0] fb;
		logic [BYTES_W-1:0] sz;
		logic               last;
		logic [PCT_W-1:0]   thr;
		int                 send_idle;
		int                 recv_idle;
	} stim_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic [IDX_W-1:0]   thread_index = '0;
	logic [BYTES_W-1:0] free_bytes = '0;
	logic [BYTES_W-1:0] size_bytes = '0;
	logic               last_sample = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         result_kind;
	logic [IDX_W-1:0]   event_thread;
	logic [BYTES_W-1:0] event_free_bytes;
	logic [BYTES_W-1:0] event_size_bytes;
	logic [IDX_W-1:0]   worst_thread;
	logic [BYTES_W-1:0] worst_free_bytes;
	logic [PCT_W-1:0]   worst_used_percent;
	logic [CNT_W-1:0]   below_count;
	logic               last_result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [PCT_W-1:0]   cfg_data = '0;

	// Stimulus and expectations
	stim_cmd_t stim_q[$];
	result_t   awaited_results[$];
	int        cur_thr;
	int        send_idle_pct;
	int        recv_idle_pct = 0;
	int        quiet_cycles;
	int        stuck_cycles = 0;

	// Predictor state
	logic [PCT_W-1:0]   thr_model = THRESHOLD_RST;
	logic               warned_model [MAX_THREADS_DEF];
	logic               tick_has_worst = 1'b0;
	logic [PCT_W-1:0]   tick_worst_pct = '0;
	logic [IDX_W-1:0]   tick_worst_idx = '0;
	logic [BYTES_W-1:0] tick_worst_free = '0;
	logic [CNT_W-1:0]   tick_below = '0;

	// Run statistics
	int mismatches = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_warn = 0;
	int n_recover = 0;
	int n_summary = 0;
	int n_cfg = 0;
	int n_drains = 0;

	stack_headroom_monitor DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample_valid       (sample_valid),
		.sample_stall       (sample_stall),
		.thread_index       (thread_index),
		.free_bytes         (free_bytes),
		.size_bytes         (size_bytes),
		.last_sample        (last_sample),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.result_kind        (result_kind),
		.event_thread       (event_thread),
		.event_free_bytes   (event_free_bytes),
		.event_size_bytes   (event_size_bytes),
		.worst_thread       (worst_thread),
		.worst_free_bytes   (worst_free_bytes),
		.worst_used_percent (worst_used_percent),
		.below_count        (below_count),
		.last_result        (last_result),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data)
	);

	always #2 clk = ~clk;

	// Free percent of a sample: clamp free to size, scale by 100, truncate
	function automatic logic [PCT_W-1:0] headroom_pct(input logic [BYTES_W-1:0] fb,
			input logic [BYTES_W-1:0] sz);
		logic [63:0] kept;
		if (sz == '0)
			return '0;
		kept = (fb > sz) ? {32'd0, sz} : {32'd0, fb};
		return PCT_W'((kept * 64'd100) / {32'd0, sz});
	endfunction

	// Work out the warning, recovery and summary that one accepted sample causes
	task automatic predict_headroom(input logic [IDX_W-1:0] idx, input logic [BYTES_W-1:0] fb,
			input logic [BYTES_W-1:0] sz, input logic last);
		logic [PCT_W-1:0] fp;
		logic             below;
		logic             has_event;
		result_t          ev;
		result_t          summ;
		fp = headroom_pct(fb, sz);
		below = fp < thr_model;
		has_event = 1'b0;
		ev = '0;
		summ = '0;
		if (!tick_has_worst || fp < tick_worst_pct) begin
			tick_has_worst = 1'b1;
			tick_worst_pct = fp;
			tick_worst_idx = idx;
			tick_worst_free = fb;
		end
		if (below && tick_below != BELOW_MAX)
			tick_below++;
		if (below && !warned_model[idx]) begin
			ev.kind = KIND_WARN;
			ev.event_thread = idx;
			ev.event_free_bytes = fb;
			ev.event_size_bytes = sz;
			warned_model[idx] = 1'b1;
			has_event = 1'b1;
			n_warn++;
		end else if (!below && warned_model[idx]) begin
			ev.kind = KIND_RECOVER;
			ev.event_thread = idx;
			warned_model[idx] = 1'b0;
			has_event = 1'b1;
			n_recover++;
		end
		if (has_event) begin
			ev.last_result = !last;
			awaited_results.insert(awaited_results.size(), ev);
		end
		// Close the tick: report the worst thread, then clear the tick state
		if (last) begin
			summ.kind = KIND_SUMMARY;
			summ.worst_thread = tick_worst_idx;
			summ.worst_free_bytes = tick_worst_free;
			summ.worst_used_percent = PCT_FULL - tick_worst_pct;
			summ.below_count = tick_below;
			summ.last_result = 1'b1;
			awaited_results.insert(awaited_results.size(), summ);
			n_summary++;
			tick_has_worst = 1'b0;
			tick_worst_pct = '0;
			tick_worst_idx = '0;
			tick_worst_free = '0;
			tick_below = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Stimulus builders
	task automatic push_sample(input int idx, input logic [BYTES_W-1:0] fb,
			input logic [BYTES_W-1:0] sz, input logic last);
		stim_cmd_t c;
		c.op = CMD_SAMPLE;
		c.idx = IDX_W'(idx);
		c.fb = fb;
		c.sz = sz;
		c.last = last;
		c.thr = '0;
		c.send_idle = 0;
		c.recv_idle = 0;
		stim_q.insert(stim_q.size(), c);
	endtask

	task automatic push_control(input stim_op_t op, input int thr, input int s_idle,
			input int r_idle);
		stim_cmd_t c;
		c.op = op;
		c.idx = '0;
		c.fb = '0;
		c.sz = '0;
		c.last = 1'b0;
		c.thr = PCT_W'(thr);
		c.send_idle = s_idle;
		c.recv_idle = r_idle;
		if (op == CMD_THRESHOLD)
			cur_thr = thr;
		stim_q.insert(stim_q.size(), c);
	endtask

	// Queue random ticks; free bytes often land near the current threshold
	task automatic queue_random_ticks(input int count, input int span);
		int left;
		int tick_len;
		int pct;
		logic [BYTES_W-1:0] fb;
		logic [BYTES_W-1:0] sz;
		left = count;
		while (left > 0) begin
			tick_len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
			if (tick_len > left)
				tick_len = left;
			for (int k = 0; k < tick_len; k++) begin
				case ($urandom_range(9))
					0:       sz = '0;
					1:       sz = '1;
					2, 3:    sz = $urandom;
					default: sz = $urandom_range(5000, 1);
				endcase
				pct = $urandom_range(1) ? cur_thr + int'($urandom_range(4)) - 2 :
					int'($urandom_range(100));
				if (pct < 0)
					pct = 0;
				if (pct > 100)
					pct = 100;
				case ($urandom_range(7))
					0:       fb = $urandom;
					1:       fb = sz + $urandom_range(64, 1);
					2:       fb = '0;
					default: fb = BYTES_W'((64'(sz) * pct) / 100);
				endcase
				push_sample($urandom_range(span - 1), fb, sz, k == tick_len - 1);
			end
			left -= tick_len;
		end
	endtask

	// Sample and threshold driver, fed from the stimulus queue
	always @(posedge clk or negedge arst_n) begin : drive_samples
		stim_cmd_t c;
		logic hold_sample;
		logic hold_cfg;
		logic nxt_sample;
		logic nxt_cfg;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			cfg_valid <= 1'b0;
			quiet_cycles = 0;
		end else begin
			hold_sample = sample_valid && sample_stall;
			hold_cfg = cfg_valid && !cfg_ready;
			if (sample_valid && !sample_stall) begin
				predict_headroom(thread_index, free_bytes, size_bytes, last_sample);
				n_samples++;
			end
			if (cfg_valid && cfg_ready) begin
				thr_model = cfg_data;
				n_cfg++;
			end
			if (awaited_results.size() == 0 && !sample_valid && !cfg_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			// Hold a stalled transfer; otherwise pick the next command
			if (!hold_sample && !hold_cfg) begin
				nxt_sample = 1'b0;
				nxt_cfg = 1'b0;
				if (stim_q.size() != 0) begin
					c = stim_q[0];
					case (c.op)
						CMD_SAMPLE: begin
							if (int'($urandom_range(99)) >= send_idle_pct) begin
								void'(stim_q.pop_front());
								thread_index <= c.idx;
								free_bytes <= c.fb;
								size_bytes <= c.sz;
								last_sample <= c.last;
								nxt_sample = 1'b1;
							end
						end
						CMD_THRESHOLD: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								void'(stim_q.pop_front());
								cfg_data <= c.thr;
								nxt_cfg = 1'b1;
							end
						end
						CMD_DRAIN: begin
							if (quiet_cycles >= SETTLE_CYCLES) begin
								void'(stim_q.pop_front());
								n_drains++;
							end
						end
						CMD_PACE: begin
							void'(stim_q.pop_front());
							send_idle_pct = c.send_idle;
							recv_idle_pct <= c.recv_idle;
						end
					endcase
				end
				sample_valid <= nxt_sample;
				cfg_valid <= nxt_cfg;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d thread %0d", result_kind, event_thread);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("event_thread", want.event_thread, event_thread);
					check_field("event_free_bytes", want.event_free_bytes, event_free_bytes);
					check_field("event_size_bytes", want.event_size_bytes, event_size_bytes);
					check_field("worst_thread", want.worst_thread, worst_thread);
					check_field("worst_free_bytes", want.worst_free_bytes, worst_free_bytes);
					check_field("worst_used_percent", want.worst_used_percent,
						worst_used_percent);
					check_field("below_count", want.below_count, below_count);
					check_field("last_result", want.last_result, last_result);
				end
			end
			result_stall <= (int'($urandom_range(99)) < recv_idle_pct);
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results still awaited", STUCK_LIMIT,
				awaited_results.size());
			$display("tb_stack_headroom_monitor: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_THREADS_DEF; i++)
			warned_model[i] = 1'b0;
		send_idle_pct = 0;
		cur_thr = THRESHOLD_RST;

		// Directed part, sender idles 28 and receiver 65 percent of cycles
		push_control(CMD_PACE, 0, 28, 65);
		push_sample(0, 32'd10, 32'd100, 1'b0);            // warn at reset threshold
		push_sample(0, 32'd50, 32'd100, 1'b1);            // recovery, then summary
		push_sample(31, 32'd0, 32'd0, 1'b0);              // zero size
		push_sample(5, 32'hFFFF_FFFF, 32'd1000, 1'b0);    // free above size
		push_sample(3, 32'd0, 32'hFFFF_FFFF, 1'b0);       // tie at zero percent
		push_sample(3, 32'd1, 32'hFFFF_FFFF, 1'b0);       // repeated thread
		push_sample(16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_sample(10, 32'd19, 32'd100, 1'b0);           // just below threshold
		push_sample(11, 32'd20, 32'd100, 1'b1);           // exactly at threshold
		push_control(CMD_THRESHOLD, 127, 0, 0);           // above 100: all below
		push_sample(5, 32'hFFFF_FFFF, 32'd1000, 1'b0);
		push_sample(26, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		push_sample(21, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
		push_control(CMD_THRESHOLD, 0, 0, 0);             // nothing below
		push_sample(31, 32'd0, 32'd0, 1'b0);
		push_sample(3, 32'd0, 32'hFFFF_FFFF, 1'b0);
		push_sample(5, 32'd7, 32'd9, 1'b0);
		push_sample(10, 32'd0, 32'd1, 1'b1);
		push_control(CMD_THRESHOLD, 100, 0, 0);
		push_sample(7, 32'd100, 32'd100, 1'b0);
		push_sample(7, 32'd99, 32'd100, 1'b1);
		push_control(CMD_THRESHOLD, 35, 0, 0);

		// Random part, first pacing
		queue_random_ticks(100, 8);
		push_control(CMD_THRESHOLD, $urandom_range(100), 0, 0);
		queue_random_ticks(100, 32);

		// Pacing swapped; pause until every result is back before the swap and after the next ticks
		push_control(CMD_DRAIN, 0, 0, 0);
		push_control(CMD_PACE, 0, 65, 28);
		push_control(CMD_THRESHOLD, $urandom_range(100), 0, 0);
		queue_random_ticks(100, 8);
		push_control(CMD_DRAIN, 0, 0, 0);
		push_control(CMD_THRESHOLD, 1, 0, 0);
		queue_random_ticks(90, 32);

		// No idling; one long tick saturates the below count
		push_control(CMD_PACE, 0, 0, 0);
		push_control(CMD_THRESHOLD, 127, 0, 0);
		for (int k = 0; k < 70; k++)
			push_sample($urandom_range(31), $urandom, $urandom, k == 69);
		push_control(CMD_THRESHOLD, $urandom_range(127), 0, 0);
		queue_random_ticks(100, 8);
		push_control(CMD_THRESHOLD, 100, 0, 0);
		queue_random_ticks(50, 32);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer and the last result, then let the block settle
		while (stim_q.size() != 0 || sample_valid || cfg_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d samples, %0d threshold writes, %0d pauses to drain",
			n_samples, n_cfg, n_drains);
		$display("checked %0d results: %0d warnings, %0d recoveries, %0d summaries",
			n_results, n_warn, n_recover, n_summary);
		if (mismatches == 0)
			$display("tb_stack_headroom_monitor: done, clean");
		else
			$display("tb_stack_headroom_monitor: done, errors");
		$finish;
	end

endmodule
